[rtl/lts_pkg.sv]
// shared constants and exp table for the top-k softmax block
// no dependencies
`default_nettype none
package lts_pkg;
  localparam int VecLen   = 256;
  localparam int Lanes    = 4;
  localparam int Groups   = VecLen / Lanes;
  localparam int GrpW     = $clog2(Groups);
  localparam int IdxW     = $clog2(VecLen);
  localparam int CntW     = $clog2(VecLen + 1);
  localparam int ExpTableBits = 10;
  localparam int ExpDrop  = (ExpTableBits < 10) ? 10 - ExpTableBits : 0;
  localparam int SumW     = 16 + $clog2(VecLen);

  localparam logic [1:0] RegInvTemp = 2'd0;
  localparam logic [1:0] RegTopK    = 2'd1;

  function automatic logic [31:0] exp_const(input logic [3:0] b);
    logic [31:0] c;
    case (b)
      4'd0:  c = 32'd4290775039;
      4'd1:  c = 32'd4286586875;
      4'd2:  c = 32'd4278222805;
      4'd3:  c = 32'd4261543595;
      4'd4:  c = 32'd4228380000;
      4'd5:  c = 32'd4162825044;
      4'd6:  c = 32'd4034748382;
      4'd7:  c = 32'd3790295335;
      4'd8:  c = 32'd3344923893;
      4'd9:  c = 32'd2605029347;
      4'd10: c = 32'd1580030169;
      4'd11: c = 32'd581260615;
      4'd12: c = 32'd78665070;
      4'd13: c = 32'd1440801;
      default: c = 32'd0;
    endcase
    return c;
  endfunction
endpackage
`default_nettype wire

[rtl/logit_temperature_topk_softmax.sv]
// Top-k softmax with temperature over a 256-entry logit vector, four lanes wide.
// Groups of four logits are stored as they arrive while the input is not
// stalled; the last group starts processing: a scale pass, a rank pass in which
// each group of four is compared against all 256 scaled values, an exp pass,
// then per group a normalizing divide and an output transfer, which the output
// stall can hold. The rank pass, which scans the copy of the scaled values one
// group at a time, takes the bulk of the time. The input is stalled meanwhile.
// Uses lts_pkg, lts_ram, lts_exp, lts_div.
`default_nettype none
module logit_temperature_topk_softmax
  import lts_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic signed [15:0] logit_a_i,
  input  wire logic signed [15:0] logit_b_i,
  input  wire logic signed [15:0] logit_c_i,
  input  wire logic signed [15:0] logit_d_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      prob_a_o,
  output logic [15:0]      prob_b_o,
  output logic [15:0]      prob_c_o,
  output logic [15:0]      prob_d_o,
  output logic             last_group_o
);
  localparam logic [2:0] StLoad  = 3'd0;
  localparam logic [2:0] StScale = 3'd1;
  localparam logic [2:0] StRank  = 3'd2;
  localparam logic [2:0] StExp   = 3'd3;
  localparam logic [2:0] StDiv   = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [15:0] inv_temp_q;
  logic [8:0]  top_k_q;
  logic [2:0]  st_q, st_d;
  logic [GrpW-1:0] grp_q, grp_d;
  logic [IdxW:0]   sc_q, sc_d;
  logic [1:0]      ph_q, ph_d;
  logic            in_acc;

  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      RegInvTemp[0]: prdata = {16'd0, inv_temp_q};
      default:       prdata = {23'd0, top_k_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_temp_q <= 16'd5120;
      top_k_q    <= 9'd40;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == RegInvTemp[0]) inv_temp_q <= pwdata[15:0];
      else if (paddr[2] == RegTopK[0]) top_k_q <= pwdata[8:0];
    end
  end

  assign in_stall_o = (st_q != StLoad);
  assign in_acc     = in_valid_i && !in_stall_o;

  // per-lane memories: logits, scaled logits (two read ports via copy), weights
  logic [Lanes-1:0][15:0] lin_wd, lg_rd, sc_rd, wt_rd, all_rd;
  logic [Lanes-1:0][15:0] sc_wd;
  logic [Lanes-1:0][15:0] wt_wd;
  logic            sc_we, wt_we;
  logic [GrpW-1:0] lg_ra, sc_ra, wt_ra, all_ra, sc_wa, wt_wa;

  assign lin_wd = {logit_d_i, logit_c_i, logit_b_i, logit_a_i};

  for (genvar l = 0; l < Lanes; l++) begin : g_mem
    lts_ram #(.Width(16), .Depth(Groups)) u_lg (.clk_i, .we_i(in_acc),
      .waddr_i(grp_q), .wdata_i(lin_wd[l]), .raddr_i(lg_ra), .rdata_o(lg_rd[l]));
    lts_ram #(.Width(16), .Depth(Groups)) u_sc (.clk_i, .we_i(sc_we),
      .waddr_i(sc_wa), .wdata_i(sc_wd[l]), .raddr_i(sc_ra), .rdata_o(sc_rd[l]));
    lts_ram #(.Width(16), .Depth(Groups)) u_sa (.clk_i, .we_i(sc_we),
      .waddr_i(sc_wa), .wdata_i(sc_wd[l]), .raddr_i(all_ra), .rdata_o(all_rd[l]));
    lts_ram #(.Width(16), .Depth(Groups)) u_wt (.clk_i, .we_i(wt_we),
      .waddr_i(wt_wa), .wdata_i(wt_wd[l]), .raddr_i(wt_ra), .rdata_o(wt_rd[l]));
  end

  // scale: one registered multiply per lane
  logic signed [32:0] prod_q [Lanes];
  logic            pv_q, pv2_q;
  logic [GrpW-1:0] pa_q, pa2_q;
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < Lanes; l++) begin
      prod_q[l] <= 33'($signed(lg_rd[l])) * 33'($signed({1'b0, inv_temp_q}))
                   + 33'sd2048;
    end
    pa2_q <= pa_q;
  end
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      if (prod_q[l] >>> 12 > 33'sd32767) sc_wd[l] = 16'h7FFF;
      else if (prod_q[l] >>> 12 < -33'sd32768) sc_wd[l] = 16'h8000;
      else sc_wd[l] = 16'(prod_q[l] >>> 12);
    end
  end
  assign sc_we = pv2_q;
  assign sc_wa = pa2_q;

  // rank counters, kept flags, running max
  logic [CntW-1:0] cnt_q [Lanes];
  logic signed [15:0] max_q, max_d;
  logic [CntW-1:0] kk;
  logic [Lanes-1:0] kp_wd, kp_cur;
  logic             kp_we;
  assign kk = (top_k_q > 9'(VecLen)) ? CntW'(VecLen) : CntW'(top_k_q);

  assign kp_we = (st_q == StRank) && (ph_q == 2'd2);
  always_comb begin
    max_d = max_q;
    for (int l = 0; l < Lanes; l++) begin
      kp_wd[l] = (kk == '0) || (cnt_q[l] < kk);
      if (kp_wd[l] && $signed(sc_rd[l]) > max_d) max_d = sc_rd[l];
    end
  end

  lts_ram #(.Width(Lanes), .Depth(Groups)) u_kp (.clk_i, .we_i(kp_we),
    .waddr_i(grp_q), .wdata_i(kp_wd), .raddr_i(grp_q), .rdata_o(kp_cur));

  // exp and divide lanes
  logic [Lanes-1:0] ex_done, dv_done;
  logic [Lanes-1:0][15:0] ex_w, dv_p;
  logic             ex_start, dv_start;
  logic [Lanes-1:0][16:0] ex_u;
  logic [SumW-1:0]  sum_q;

  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    assign ex_u[l] = 17'($signed({max_q[15], max_q}) - $signed({sc_rd[l][15], sc_rd[l]}));
    lts_exp u_exp (.clk_i, .rst_ni, .start_i(ex_start), .keep_i(kp_cur[l]),
      .u_i(ex_u[l]), .done_o(ex_done[l]), .weight_o(ex_w[l]));
    lts_div u_div (.clk_i, .rst_ni, .start_i(dv_start), .w_i(wt_rd[l]),
      .sum_i(sum_q), .done_o(dv_done[l]), .prob_o(dv_p[l]));
  end
  assign wt_wd = ex_w;
  assign wt_we = ex_done[0];
  assign wt_wa = grp_q;

  logic [SumW-1:0] gsum;
  always_comb begin
    gsum = '0;
    for (int l = 0; l < Lanes; l++) gsum = gsum + SumW'(ex_w[l]);
  end

  // sequencer
  assign lg_ra  = sc_q[GrpW-1:0];
  assign sc_ra  = grp_q;
  assign wt_ra  = grp_q;
  assign all_ra = sc_q[GrpW-1:0];

  logic [15:0] ob_q [Lanes];
  logic        ov_q, ol_q;
  logic        scan_v;
  assign scan_v = (st_q == StRank) && (ph_q == 2'd1) && (sc_q != '0) &&
                  (sc_q <= (IdxW+1)'(Groups));

  always_comb begin
    st_d = st_q; grp_d = grp_q; sc_d = sc_q; ph_d = ph_q;
    ex_start = 1'b0; dv_start = 1'b0;
    case (st_q)
      StLoad: begin
        if (in_acc) begin
          grp_d = grp_q + GrpW'(1);
          if (grp_q == GrpW'(Groups - 1)) begin
            st_d = StScale; sc_d = '0;
          end
        end
      end
      StScale: begin
        sc_d = sc_q + (IdxW+1)'(1);
        if (sc_q == (IdxW+1)'(Groups + 2)) begin
          st_d = StRank; sc_d = '0; grp_d = '0; ph_d = 2'd0;
        end
      end
      StRank: begin
        case (ph_q)
          2'd0: begin ph_d = 2'd1; sc_d = '0; end
          2'd1: begin
            sc_d = sc_q + (IdxW+1)'(1);
            if (sc_q == (IdxW+1)'(Groups + 1)) ph_d = 2'd2;
          end
          default: begin
            ph_d = 2'd0;
            grp_d = grp_q + GrpW'(1);
            if (grp_q == GrpW'(Groups - 1)) begin
              st_d = StExp; ph_d = 2'd0;
            end
          end
        endcase
      end
      StExp: begin
        case (ph_q)
          2'd0: ph_d = 2'd1;
          2'd1: begin ex_start = 1'b1; ph_d = 2'd2; end
          default: begin
            if (ex_done[0]) begin
              ph_d = 2'd0;
              grp_d = grp_q + GrpW'(1);
              if (grp_q == GrpW'(Groups - 1)) st_d = StDiv;
            end
          end
        endcase
      end
      StDiv: begin
        case (ph_q)
          2'd0: ph_d = 2'd1;
          2'd1: begin dv_start = 1'b1; ph_d = 2'd2; end
          default: if (dv_done[0]) st_d = StOut;
        endcase
      end
      StOut: begin
        if (!ov_q || !out_stall_i) begin
          ph_d = 2'd0;
          grp_d = grp_q + GrpW'(1);
          st_d = (grp_q == GrpW'(Groups - 1)) ? StLoad : StDiv;
        end
      end
      default: st_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StLoad; grp_q <= '0; sc_q <= '0; ph_q <= '0;
      pv_q <= 1'b0; pv2_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; grp_q <= grp_d; sc_q <= sc_d; ph_q <= ph_d;
      pv_q  <= (st_q == StScale) && (sc_q < (IdxW+1)'(Groups));
      pv2_q <= pv_q;
      if (st_q == StOut && (!ov_q || !out_stall_i)) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q <= sc_q[GrpW-1:0];
    if (st_q == StRank && ph_q == 2'd0) begin
      for (int l = 0; l < Lanes; l++) cnt_q[l] <= '0;
      if (grp_q == '0) max_q <= 16'sh8000;
    end else if (scan_v) begin
      for (int l = 0; l < Lanes; l++) begin
        cnt_q[l] <= cnt_q[l]
          + CntW'($signed(all_rd[0]) > $signed(sc_rd[l]))
          + CntW'($signed(all_rd[1]) > $signed(sc_rd[l]))
          + CntW'($signed(all_rd[2]) > $signed(sc_rd[l]))
          + CntW'($signed(all_rd[3]) > $signed(sc_rd[l]));
      end
    end else if (st_q == StRank && ph_q == 2'd2) begin
      max_q <= max_d;
    end
    if (st_q == StRank && grp_q == '0 && ph_q == 2'd0) sum_q <= '0;
    else if (ex_done[0]) sum_q <= sum_q + gsum;
    if (st_q == StOut && (!ov_q || !out_stall_i)) begin
      for (int l = 0; l < Lanes; l++) ob_q[l] <= dv_p[l];
      ol_q <= (grp_q == GrpW'(Groups - 1));
    end
  end

  assign out_valid_o  = ov_q;
  assign prob_a_o     = ob_q[0];
  assign prob_b_o     = ob_q[1];
  assign prob_c_o     = ob_q[2];
  assign prob_d_o     = ob_q[3];
  assign last_group_o = ol_q;
endmodule
`default_nettype wire

[rtl/lts_ram.sv]
// generic single-port-write, one-read ram with registered read data
// no dependencies
`default_nettype none
module lts_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[rtl/lts_exp.sv]
// one lane's exp unit: one bit of the exponent per cycle, then weight scaling
// uses lts_pkg
`default_nettype none
module lts_exp
  import lts_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        keep_i,
  input  wire logic [16:0] u_i,
  output logic             done_o,
  output logic [15:0]      weight_o
);
  logic [32:0] acc_q, acc_d;
  logic [13:0] u_q, u_d;
  logic [3:0]  bit_q, bit_d;
  logic        busy_q, busy_d, zero_q, zero_d, fin_q, fin_d;
  logic [63:0] prod;
  logic [15:0] w_q, w_d;

  always_comb begin
    acc_d = acc_q; u_d = u_q; bit_d = bit_q; busy_d = busy_q;
    zero_d = zero_q; fin_d = 1'b0; w_d = w_q;
    prod = 64'd0;
    if (start_i) begin
      acc_d  = 33'h1_0000_0000;
      u_d    = u_i[13:0] & ~14'((1 << ExpDrop) - 1);
      bit_d  = 4'd0;
      busy_d = 1'b1;
      zero_d = !keep_i || (u_i >= 17'd16384);
    end else if (busy_q) begin
      if (bit_q == 4'd14) begin
        prod   = 64'(acc_q) * 64'd65535 + 64'h8000_0000;
        w_d    = zero_q ? 16'd0 : prod[47:32];
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end else begin
        if (u_q[bit_q]) begin
          prod  = 64'(acc_q) * 64'(exp_const(bit_q)) + 64'h8000_0000;
          acc_d = {1'b0, prod[64-1:32]};
        end
        bit_d = bit_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; u_q <= u_d; bit_q <= bit_d; zero_q <= zero_d; w_q <= w_d;
  end

  assign done_o   = fin_q;
  assign weight_o = w_q;
endmodule
`default_nettype wire

[rtl/lts_div.sv]
// one lane's restoring divider for the final normalization, one quotient bit per cycle
// uses lts_pkg
`default_nettype none
module lts_div
  import lts_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [15:0]     w_i,
  input  wire logic [SumW-1:0] sum_i,
  output logic                 done_o,
  output logic [15:0]          prob_o
);
  localparam int NumW = 32 + 1;
  logic [NumW-1:0] num_q, num_d;
  logic [SumW:0]   rem_q, rem_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [5:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d, fin_q, fin_d;
  logic [SumW:0]   trial;

  always_comb begin
    num_d = num_q; rem_d = rem_q; quo_d = quo_q; cnt_d = cnt_q;
    busy_d = busy_q; fin_d = 1'b0; trial = '0;
    if (start_i) begin
      num_d  = NumW'({w_i, 16'd0}) + NumW'(sum_i >> 1);
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = 6'(NumW);
      busy_d = (sum_i != '0);
      fin_d  = (sum_i == '0);
    end else if (busy_q) begin
      trial = {rem_q[SumW-1:0], num_q[NumW-1]};
      num_d = {num_q[NumW-2:0], 1'b0};
      if (trial >= {1'b0, sum_i}) begin
        rem_d = trial - {1'b0, sum_i};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; quo_q <= quo_d; cnt_q <= cnt_d;
  end

  assign done_o = fin_q;
  assign prob_o = (quo_q > NumW'(65535)) ? 16'hFFFF : quo_q[15:0];
endmodule
`default_nettype wire
